// File: hdl/plsr_pkg.sv
// Package: element type codes, float formats and shared types for the lane sum reducer.
package plsr_pkg;

    localparam int unsigned WordW = 64;
    localparam int unsigned TypeW = 4;
    localparam int unsigned AddrW = 2;

    typedef enum logic [TypeW-1:0] {
        ET_INT8    = 4'd0,
        ET_UINT8   = 4'd1,
        ET_INT16   = 4'd2,
        ET_UINT16  = 4'd3,
        ET_INT32   = 4'd4,
        ET_UINT32  = 4'd5,
        ET_INT64   = 4'd6,
        ET_UINT64  = 4'd7,
        ET_FLOAT32 = 4'd8,
        ET_FLOAT64 = 4'd9
    } t_elem_type;

    localparam logic [AddrW-1:0] REG_ELEMENT_TYPE = 2'd0;

    // control carried down the pipeline with each word
    typedef struct packed {
        logic       valid;
        logic [1:0] lane_sz;   // 0:8 1:16 2:32 3:64
        logic       is_int;
        logic       is_f32;
        logic       is_f64;
        logic       pass;
    } t_ctl;

    // per-lane float pipeline state after alignment
    typedef struct packed {
        logic        special;
        logic [63:0] special_val;
        logic        sign;
        logic [11:0] exp;
        logic [56:0] mag;     // signed-free magnitude with guard/round/sticky
    } t_fstage;

endpackage

// File: hdl/plsr_fadd.sv
// Pipelined IEEE 754 adder, round-to-nearest-even, binary32 or binary64 by parameter.
module plsr_fadd
    import plsr_pkg::*;
#(
    parameter int unsigned EW = 11,
    parameter int unsigned MW = 52
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [EW+MW:0]   i_a,
    input  logic [EW+MW:0]   i_b,
    output logic [EW+MW:0]   o_sum
);
    localparam int unsigned W   = EW + MW + 1;
    localparam int unsigned SW  = MW + 5;          // carry, hidden, mantissa, guard, round, sticky
    localparam int unsigned LZW = $clog2(SW + 1);
    localparam logic [EW-1:0] EMAX = {EW{1'b1}};
    localparam logic [W-1:0] QBIT = W'(1) << (MW - 1);
    localparam logic [W-1:0] DNAN = {1'b0, EMAX, 1'b1, {(MW-1){1'b0}}};

    function automatic logic is_nan(input logic [W-1:0] x);
        is_nan = (x[W-2 -: EW] == EMAX) && (x[MW-1:0] != '0);
    endfunction

    // stage 1: classify, order operands, align
    logic [W-1:0]  big, lit;
    logic [EW-1:0] eb, el, ebx, elx;
    logic [EW:0]   ediff;
    logic [SW-1:0] mb, ml, mls;
    logic          sticky;
    logic          sp1;
    logic [W-1:0]  spv1;
    logic [SW:0]   shifted_mask;

    always_comb begin
        if (i_a[W-2:0] >= i_b[W-2:0]) begin
            big = i_a;
            lit = i_b;
        end else begin
            big = i_b;
            lit = i_a;
        end
        eb  = big[W-2 -: EW];
        el  = lit[W-2 -: EW];
        ebx = (eb == '0) ? EW'(1) : eb;
        elx = (el == '0) ? EW'(1) : el;
        ediff = {1'b0, ebx} - {1'b0, elx};
        mb = {1'b0, (eb != '0), big[MW-1:0], 3'b000};
        ml = {1'b0, (el != '0), lit[MW-1:0], 3'b000};
        shifted_mask = '0;
        if (ediff >= (EW+1)'(SW)) begin
            mls    = '0;
            sticky = (ml != '0);
        end else begin
            mls = ml >> ediff;
            shifted_mask = ({(SW+1){1'b1}} << ediff);
            sticky = ((ml & ~shifted_mask[SW-1:0]) != '0);
        end
        sp1  = 1'b1;
        spv1 = '0;
        if (is_nan(i_a)) begin
            spv1 = i_a | QBIT;
        end else if (is_nan(i_b)) begin
            spv1 = i_b | QBIT;
        end else if (eb == EMAX && el == EMAX && big[W-1] != lit[W-1]) begin
            spv1 = DNAN;
        end else if (eb == EMAX) begin
            spv1 = big;
        end else begin
            sp1 = 1'b0;
        end
    end

    logic          r1_sp, r1_sub, r1_sign, r1_stk, r1_zsgn;
    logic [W-1:0]  r1_spv;
    logic [EW-1:0] r1_exp;
    logic [SW-1:0] r1_mb, r1_ml;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_sp   <= sp1;
            r1_spv  <= spv1;
            r1_sub  <= i_a[W-1] ^ i_b[W-1];
            r1_sign <= big[W-1];
            r1_zsgn <= i_a[W-1] & i_b[W-1];
            r1_exp  <= ebx;
            r1_mb   <= mb;
            r1_ml   <= mls;
            r1_stk  <= sticky;
        end
    end

    // stage 2: add or subtract, sticky folded into lsb
    logic [SW-1:0] ml2, sum2;
    always_comb begin
        ml2  = r1_ml | SW'(r1_stk);
        sum2 = r1_sub ? (r1_mb - ml2) : (r1_mb + ml2);
    end

    logic          r2_sp, r2_sign, r2_zsgn, r2_sub;
    logic [W-1:0]  r2_spv;
    logic [EW-1:0] r2_exp;
    logic [SW-1:0] r2_sum;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_sp   <= r1_sp;
            r2_spv  <= r1_spv;
            r2_sign <= r1_sign;
            r2_zsgn <= r1_zsgn;
            r2_sub  <= r1_sub;
            r2_exp  <= r1_exp;
            r2_sum  <= sum2;
        end
    end

    // stage 3: leading-zero count
    logic [LZW-1:0] lz;
    always_comb begin
        lz = LZW'(SW);
        for (int k = 0; k < SW; k++) begin
            if (r2_sum[k]) lz = LZW'(SW - 1 - k);
        end
    end

    logic          r3_sp, r3_sign, r3_zsgn, r3_sub;
    logic [W-1:0]  r3_spv;
    logic [EW-1:0] r3_exp;
    logic [SW-1:0] r3_sum;
    logic [LZW-1:0] r3_lz;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_sp   <= r2_sp;
            r3_spv  <= r2_spv;
            r3_sign <= r2_sign;
            r3_zsgn <= r2_zsgn;
            r3_sub  <= r2_sub;
            r3_exp  <= r2_exp;
            r3_sum  <= r2_sum;
            r3_lz   <= lz;
        end
    end

    // stage 4: normalize
    // value = sum * 2^(exp - bias - MW - 3); the msb position SW-2 corresponds to exp
    logic [EW+1:0] e4;
    logic [SW-1:0] m4;
    logic          ovf;
    always_comb begin
        m4 = '0;
        e4 = '0;
        ovf = r3_sum[SW-1];
        if (ovf) begin
            m4 = (r3_sum >> 1) | SW'(r3_sum[0]);
            e4 = (EW+2)'(r3_exp) + (EW+2)'(1);
        end else if ((EW+2)'(r3_lz) - (EW+2)'(1) < (EW+2)'(r3_exp)) begin
            m4 = r3_sum << (r3_lz - LZW'(1));
            e4 = (EW+2)'(r3_exp) - ((EW+2)'(r3_lz) - (EW+2)'(1));
        end else begin
            // subnormal: shift only down to exponent 1
            m4 = r3_sum << (r3_exp - EW'(1));
            e4 = '0;
        end
    end

    logic          r4_sp, r4_sign, r4_zero;
    logic [W-1:0]  r4_spv;
    logic [EW+1:0] r4_exp;
    logic [SW-1:0] r4_man;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_sp   <= r3_sp;
            r4_spv  <= r3_spv;
            r4_sign <= (r3_sum == '0) ? (r3_sub ? 1'b0 : r3_zsgn) : r3_sign;
            r4_zero <= (r3_sum == '0);
            r4_exp  <= e4;
            r4_man  <= m4;
        end
    end

    // stage 5: round to nearest even, pack
    logic [MW:0]   rm;
    logic [EW+1:0] re;
    logic          rup;
    logic [W-1:0]  res;
    always_comb begin
        rup = r4_man[2] & (r4_man[1] | r4_man[0] | r4_man[3]);
        rm  = {1'b0, r4_man[MW+2:3]} + (MW+1)'(rup);
        re  = r4_exp;
        if (rm[MW] && r4_man[MW+3] == 1'b0 && re == '0) begin
            re = (EW+2)'(1);
        end
        res = '0;
        if (r4_sp) begin
            res = r4_spv;
        end else if (r4_zero) begin
            res = {r4_sign, {(W-1){1'b0}}};
        end else begin
            if (rm[MW] && r4_man[MW+3]) begin
                // mantissa overflowed to next binade
                re = re + (EW+2)'(1);
            end
            if (re >= (EW+2)'(EMAX)) begin
                res = {r4_sign, EMAX, {MW{1'b0}}};
            end else begin
                res = {r4_sign, re[EW-1:0], rm[MW-1:0]};
            end
        end
    end

    logic [W-1:0] r5_res;
    always_ff @(posedge i_clk) begin
        if (i_en) r5_res <= res;
    end
    assign o_sum = r5_res;

endmodule

// File: hdl/plsr_int_lanes.sv
// Integer lane adders: carry chain broken at the configured lane width.
module plsr_int_lanes
    import plsr_pkg::*;
(
    input  logic [WordW-1:0] i_a,
    input  logic [WordW-1:0] i_b,
    input  logic [1:0]       i_lane_sz,
    output logic [WordW-1:0] o_sum
);
    logic [8:0] seg [8];
    logic [8:0] cin;
    logic       brk;

    always_comb begin
        cin[0] = 1'b0;
        for (int k = 0; k < 8; k++) begin
            seg[k] = {1'b0, i_a[8*k +: 8]} + {1'b0, i_b[8*k +: 8]} + 9'(cin[k]);
            case (i_lane_sz)
                2'd0:    brk = 1'b1;
                2'd1:    brk = (k % 2) == 1;
                2'd2:    brk = (k % 4) == 3;
                default: brk = 1'b0;
            endcase
            cin[k+1] = seg[k][8] & ~brk;
            o_sum[8*k +: 8] = seg[k][7:0];
        end
    end
endmodule

// File: hdl/packed_lane_sum_reduce.sv
// Top level: lane-wise sum of two packed 64-bit words with APB type register.
//  channel | dir | handshake           | payload
//  in      | in  | i_valid / o_ready   | i_accum_word, i_contrib_word
//  out     | out | o_valid / i_ready   | o_sum_word
//  cfg     | in  | APB psel/penable    | element_type at 0x0
// One word per cycle unless the output stalls; each word passes the five-stage float adders, then the output register.
// Pipeline advances when the output register is empty or being taken.
// Reset clears valids and element type; stall holds the whole pipeline.
module packed_lane_sum_reduce
    import plsr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WordW-1:0] i_accum_word,
    input  logic [WordW-1:0] i_contrib_word,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WordW-1:0] o_sum_word,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW+1:0] paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    localparam int unsigned Depth = 5;

    logic [TypeW-1:0] r_etype;
    logic             adv;
    t_ctl             n_ctl;
    t_ctl             r_ctl [Depth];
    logic [WordW-1:0] r_pass [Depth];
    logic [WordW-1:0] int_sum, f64_sum;
    logic [31:0]      f32_lo, f32_hi;
    logic [WordW-1:0] n_out;
    logic [WordW-1:0] r_out;
    logic             r_out_v;

    assign pready = 1'b1;
    assign prdata = (paddr[AddrW+1:2] == REG_ELEMENT_TYPE) ? {28'd0, r_etype} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_etype <= '0;
        end else if (psel && penable && pwrite && paddr[AddrW+1:2] == REG_ELEMENT_TYPE) begin
            r_etype <= pwdata[TypeW-1:0];
        end
    end

    assign adv     = !r_out_v || i_ready;
    assign o_ready = adv;

    always_comb begin
        n_ctl = '0;
        n_ctl.valid = i_valid;
        case (t_elem_type'(r_etype))
            ET_INT8, ET_UINT8: begin
                n_ctl.is_int = 1'b1; n_ctl.lane_sz = 2'd0;
            end
            ET_INT16, ET_UINT16: begin
                n_ctl.is_int = 1'b1; n_ctl.lane_sz = 2'd1;
            end
            ET_INT32, ET_UINT32: begin
                n_ctl.is_int = 1'b1; n_ctl.lane_sz = 2'd2;
            end
            ET_INT64, ET_UINT64: begin
                n_ctl.is_int = 1'b1; n_ctl.lane_sz = 2'd3;
            end
            ET_FLOAT32: n_ctl.is_f32 = 1'b1;
            ET_FLOAT64: n_ctl.is_f64 = 1'b1;
            default:    n_ctl.pass = 1'b1;
        endcase
    end

    plsr_int_lanes u_int (
        .i_a(i_accum_word), .i_b(i_contrib_word), .i_lane_sz(n_ctl.lane_sz), .o_sum(int_sum)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < Depth; k++) r_ctl[k] <= '0;
        end else if (adv) begin
            r_ctl[0] <= n_ctl;
            for (int k = 1; k < Depth; k++) r_ctl[k] <= r_ctl[k-1];
        end
    end

    // integer result or untouched word rides alongside the float stages
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_pass[0] <= n_ctl.is_int ? int_sum : i_accum_word;
            for (int k = 1; k < Depth; k++) r_pass[k] <= r_pass[k-1];
        end
    end

    plsr_fadd #(.EW(8), .MW(23)) u_f32_lo (
        .i_clk(i_clk), .i_en(adv),
        .i_a(i_accum_word[31:0]), .i_b(i_contrib_word[31:0]), .o_sum(f32_lo)
    );
    plsr_fadd #(.EW(8), .MW(23)) u_f32_hi (
        .i_clk(i_clk), .i_en(adv),
        .i_a(i_accum_word[63:32]), .i_b(i_contrib_word[63:32]), .o_sum(f32_hi)
    );
    plsr_fadd #(.EW(11), .MW(52)) u_f64 (
        .i_clk(i_clk), .i_en(adv),
        .i_a(i_accum_word), .i_b(i_contrib_word), .o_sum(f64_sum)
    );

    // merge
    always_comb begin
        if (r_ctl[Depth-1].is_f32) n_out = {f32_hi, f32_lo};
        else if (r_ctl[Depth-1].is_f64) n_out = f64_sum;
        else n_out = r_pass[Depth-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (adv) begin
            r_out_v <= r_ctl[Depth-1].valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) r_out <= n_out;
    end

    assign o_valid    = r_out_v;
    assign o_sum_word = r_out;

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_sum_word))
        else $error("output word changed under stall");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready == (!o_valid || i_ready))
        else $error("ready does not follow output register");
    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctl[0].valid |-> $onehot({r_ctl[0].is_int, r_ctl[0].is_f32,
                                    r_ctl[0].is_f64, r_ctl[0].pass}))
        else $error("lane mode not one-hot");

endmodule
